// ===== hdl/sit_pkg.sv =====
// shared types and constants for the segment intersection test
// no dependencies
package sit_pkg;

  localparam int OutBits = 24;

  // orientation codes
  typedef enum logic [1:0] {
    ORI_ZERO = 2'd0,
    ORI_POS  = 2'd1,
    ORI_NEG  = 2'd2
  } ori_t;

endpackage

// ===== hdl/sit_div.sv =====
// pipelined signed divider, restoring, one quotient bit per stage
// depends on nothing; quotient truncates toward zero
module sit_div #(
  parameter int NumBits = 56,
  parameter int DenBits = 34,
  parameter int TagBits = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic signed [NumBits-1:0]  num,
  input  logic signed [DenBits-1:0]  den,
  input  logic        [TagBits-1:0]  tag_in,
  output logic                       out_valid,
  output logic signed [NumBits:0]    quo,
  output logic        [TagBits-1:0]  tag_out
);

  localparam int Stages = NumBits;
  localparam int RemBits = DenBits + 1;

  logic [Stages:0]               vld;
  logic [NumBits-1:0]            qr  [Stages+1];
  logic [RemBits-1:0]            rem [Stages+1];
  logic [DenBits-1:0]            dm  [Stages+1];
  logic                          neg [Stages+1];
  logic [TagBits-1:0]            tg  [Stages+1];

  // stage 0 takes magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      qr[0]  <= num[NumBits-1] ? NumBits'(-num) : num;
      dm[0]  <= den[DenBits-1] ? DenBits'(-den) : den;
      rem[0] <= '0;
      neg[0] <= num[NumBits-1] ^ den[DenBits-1];
      tg[0]  <= tag_in;
    end
  end

  // one bit a stage
  for (genvar i = 0; i < Stages; i++) begin : g_st
    logic [RemBits-1:0] sh;
    logic [RemBits:0]   df;
    always_comb begin
      sh = {rem[i][RemBits-2:0], qr[i][NumBits-1]};
      df = {1'b0, sh} - {2'b0, dm[i]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= df[RemBits] ? sh : df[RemBits-1:0];
        qr[i+1]  <= {qr[i][NumBits-2:0], ~df[RemBits]};
        dm[i+1]  <= dm[i];
        neg[i+1] <= neg[i];
        tg[i+1]  <= tg[i];
      end
    end
  end

  assign out_valid = vld[Stages];
  assign quo = neg[Stages] ? -$signed({1'b0, qr[Stages]}) : $signed({1'b0, qr[Stages]});
  assign tag_out = tg[Stages];

endmodule

// ===== hdl/segment_intersection_test_top.sv =====
// segment intersection test top level
// depends on sit_pkg and sit_div
//
// usage: one segment pair PQ/RS enters per beat on the s_axis group,
// packed p_x,p_y,q_x,q_y,r_x,r_y,s_x,s_y from bit 0 up. one result beat
// leaves on m_axis: tdata holds cross_x then cross_y, tuser holds
// intersects (bit 0) and point_valid (bit 1).
// throughput: one pair per cycle while the receiver does not stall. the
// pipe runs coordinate differences, cross products, determinant and flags,
// then a restoring divider with an input register and one quotient bit per
// stage (3*COORD_BITS+FRAC_BITS+5 stages), then an output register.
// the whole pipe advances together: when the receiver stalls with a
// result held, every stage freezes and s_axis_tready drops, so nothing
// is lost or repeated. a bubble in front of the output is filled.
// reset clears all valid bits; payload registers are not reset.
module segment_intersection_test_top #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // p_x, p_y, q_x, q_y, r_x, r_y, s_x, s_y from bit 0 up
  input  logic [((8*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // cross_x, cross_y from bit 0 up
  output logic [47:0]             m_axis_tdata,
  // intersects, point_valid from bit 0 up
  output logic [1:0]              m_axis_tuser
);

  localparam int C   = COORD_BITS;
  localparam int D1  = C + 1;          // differences
  localparam int P1  = 2 * D1;         // products
  localparam int O1  = P1 + 1;         // orientation sum
  localparam int CB  = 2 * C + 2;      // c1, c2 width
  localparam int NB  = 3 * C + 5;      // numerator before scale
  localparam int DB  = 2 * D1 + 1;     // determinant
  localparam int NS  = NB + FRAC_BITS; // scaled numerator
  localparam int OB  = sit_pkg::OutBits;

  logic en;
  logic out_full;
  assign en = !out_full || m_axis_tready;
  assign s_axis_tready = en;

  logic signed [C-1:0] px, py, qx, qy, rx, ry, sx, sy;
  assign px = s_axis_tdata[0*C +: C];
  assign py = s_axis_tdata[1*C +: C];
  assign qx = s_axis_tdata[2*C +: C];
  assign qy = s_axis_tdata[3*C +: C];
  assign rx = s_axis_tdata[4*C +: C];
  assign ry = s_axis_tdata[5*C +: C];
  assign sx = s_axis_tdata[6*C +: C];
  assign sy = s_axis_tdata[7*C +: C];

  // stage 1: coordinate differences, registered inputs
  logic v1;
  logic signed [C-1:0]  r_px, r_py, r_qx, r_qy, r_rx, r_ry, r_sx, r_sy;
  logic signed [D1-1:0] a1, b1, a2, b2;
  logic signed [D1-1:0] dxr, dyr, dxs, dys, dxp, dyp, dxq, dyq;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      r_px <= px; r_py <= py; r_qx <= qx; r_qy <= qy;
      r_rx <= rx; r_ry <= ry; r_sx <= sx; r_sy <= sy;
      a1  <= D1'(qy) - D1'(py);
      b1  <= D1'(px) - D1'(qx);
      a2  <= D1'(sy) - D1'(ry);
      b2  <= D1'(rx) - D1'(sx);
      dxr <= D1'(rx) - D1'(qx); dyr <= D1'(ry) - D1'(qy);
      dxs <= D1'(sx) - D1'(qx); dys <= D1'(sy) - D1'(qy);
      dxp <= D1'(px) - D1'(sx); dyp <= D1'(py) - D1'(sy);
      dxq <= D1'(qx) - D1'(sx); dyq <= D1'(qy) - D1'(sy);
    end
  end

  // bounding box checks on registered coordinates
  function automatic logic in_box(input logic signed [C-1:0] ax, ay, bx, by, cx, cy);
    logic signed [C-1:0] lx, hx, ly, hy;
    begin
      lx = (ax < cx) ? ax : cx; hx = (ax < cx) ? cx : ax;
      ly = (ay < cy) ? ay : cy; hy = (ay < cy) ? cy : ay;
      in_box = (bx >= lx) && (bx <= hx) && (by >= ly) && (by <= hy);
    end
  endfunction

  // stage 2: products
  logic v2;
  logic signed [P1-1:0] m1a, m1b, m2a, m2b, m3a, m3b, m4a, m4b;
  logic signed [CB-1:0] c1, c2;
  logic signed [P1-1:0] d_a, d_b;
  logic signed [D1-1:0] a1_2, b1_2, a2_2, b2_2;
  logic [3:0] box2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      // orient(a,b,c) = (by-ay)*(cx-bx) - (bx-ax)*(cy-by)
      m1a <= a1 * dxr;  m1b <= (-b1) * dyr;
      m2a <= a1 * dxs;  m2b <= (-b1) * dys;
      m3a <= a2 * dxp;  m3b <= (-b2) * dyp;
      m4a <= a2 * dxq;  m4b <= (-b2) * dyq;
      c1 <= CB'(a1 * r_px) + CB'(b1 * r_py);
      c2 <= CB'(a2 * r_rx) + CB'(b2 * r_ry);
      d_a <= a1 * b2;
      d_b <= a2 * b1;
      a1_2 <= a1; b1_2 <= b1; a2_2 <= a2; b2_2 <= b2;
      box2[0] <= in_box(r_px, r_py, r_rx, r_ry, r_qx, r_qy);
      box2[1] <= in_box(r_px, r_py, r_sx, r_sy, r_qx, r_qy);
      box2[2] <= in_box(r_rx, r_ry, r_px, r_py, r_sx, r_sy);
      box2[3] <= in_box(r_rx, r_ry, r_qx, r_qy, r_sx, r_sy);
    end
  end

  // stage 3: orientation sums, determinant, numerator products
  logic v3;
  logic signed [O1-1:0] o1s, o2s, o3s, o4s;
  logic signed [DB-1:0] det3;
  logic signed [NB-1:0] nx_a, nx_b, ny_a, ny_b;
  logic [3:0] box3;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      o1s <= O1'(m1a) - O1'(m1b);
      o2s <= O1'(m2a) - O1'(m2b);
      o3s <= O1'(m3a) - O1'(m3b);
      o4s <= O1'(m4a) - O1'(m4b);
      det3 <= DB'(d_a) - DB'(d_b);
      nx_a <= NB'(c1 * b2_2); nx_b <= NB'(c2 * b1_2);
      ny_a <= NB'(a1_2 * c2); ny_b <= NB'(a2_2 * c1);
      box3 <= box2;
    end
  end

  function automatic sit_pkg::ori_t ori(input logic signed [O1-1:0] d);
    if (d == '0) ori = sit_pkg::ORI_ZERO;
    else if (d[O1-1]) ori = sit_pkg::ORI_NEG;
    else ori = sit_pkg::ORI_POS;
  endfunction

  // stage 4: flags and scaled numerators
  logic v4;
  logic gen4, hit4;
  logic signed [NS-1:0] numx4, numy4;
  logic signed [DB-1:0] det4;
  sit_pkg::ori_t e1, e2, e3, e4;
  always_comb begin
    e1 = ori(o1s); e2 = ori(o2s); e3 = ori(o3s); e4 = ori(o4s);
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      gen4 <= (e1 != e2) && (e3 != e4) && (det3 != '0);
      hit4 <= (e1 == sit_pkg::ORI_ZERO && box3[0]) ||
              (e2 == sit_pkg::ORI_ZERO && box3[1]) ||
              (e3 == sit_pkg::ORI_ZERO && box3[2]) ||
              (e4 == sit_pkg::ORI_ZERO && box3[3]);
      numx4 <= NS'(nx_a - nx_b) <<< FRAC_BITS;
      numy4 <= NS'(ny_a - ny_b) <<< FRAC_BITS;
      det4  <= (det3 == '0) ? DB'(1) : det3;
    end
  end

  // dividers, flags ride in the tag
  logic dvx, dvy;
  logic signed [NS:0] qx_d, qy_d;
  logic [1:0] tagx, tagy;
  sit_div #(.NumBits(NS), .DenBits(DB), .TagBits(2)) u_divx (
    .clk(clk), .rst(rst), .en(en), .in_valid(v4), .num(numx4), .den(det4),
    .tag_in({hit4, gen4}), .out_valid(dvx), .quo(qx_d), .tag_out(tagx)
  );
  sit_div #(.NumBits(NS), .DenBits(DB), .TagBits(2)) u_divy (
    .clk(clk), .rst(rst), .en(en), .in_valid(v4), .num(numy4), .den(det4),
    .tag_in({hit4, gen4}), .out_valid(dvy), .quo(qy_d), .tag_out(tagy)
  );

  function automatic logic [OB-1:0] sat(input logic signed [NS:0] q);
    if (q > $signed((NS+1)'((1 << (OB-1)) - 1))) sat = OB'((1 << (OB-1)) - 1);
    else if (q < -$signed((NS+1)'(1 << (OB-1)))) sat = OB'(1 << (OB-1));
    else sat = q[OB-1:0];
  endfunction

  // output register
  logic [OB-1:0] ox, oy;
  logic oint, opv;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (en) begin
      out_full <= dvx;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      opv  <= tagx[0];
      oint <= tagx[0] | tagx[1];
      ox   <= tagx[0] ? sat(qx_d) : '0;
      oy   <= tagx[0] ? sat(qy_d) : '0;
    end
  end

  assign m_axis_tvalid = out_full;
  assign m_axis_tdata  = {oy, ox};
  assign m_axis_tuser  = {opv, oint};

  // checks
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    dvx == dvy) else $error("dividers out of step");
  a_div_tag: assert property (@(posedge clk) disable iff (rst)
    dvx |-> tagx == tagy) else $error("divider tags differ");
  a_pv_int: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("point without intersection");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result lost in stall");

endmodule

// ===== tb/segment_intersection_test_top_checker.sv =====
// checker for the segment intersection block: watches both stream groups,
// predicts each result from the accepted segment pair and compares fields
// depends on nothing but the port widths of segment_intersection_test_top
module segment_intersection_test_top_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [47:0]  m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  output int           errors,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        hit;
    logic        has_point;
    logic [23:0] x;
    logic [23:0] y;
  } crossing_t;

  crossing_t crossings[$];

  assign pending = crossings.size();

  // orientation: 0 collinear, 1 one side, 2 other side
  function automatic int side_of(longint ax, longint ay, longint bx, longint by,
                                 longint cx, longint cy);
    longint d;
    d = (by - ay) * (cx - bx) - (bx - ax) * (cy - by);
    if (d == 0) return 0;
    return (d > 0) ? 1 : 2;
  endfunction

  function automatic bit in_bounds(longint ax, longint ay, longint bx, longint by,
                                   longint cx, longint cy);
    longint lox, hix, loy, hiy;
    lox = (ax < cx) ? ax : cx;
    hix = (ax < cx) ? cx : ax;
    loy = (ay < cy) ? ay : cy;
    hiy = (ay < cy) ? cy : ay;
    return bx >= lox && bx <= hix && by >= loy && by <= hiy;
  endfunction

  // q16.8 quotient truncated toward zero, saturated to 24 bits
  function automatic logic [23:0] fixed_quot(longint num, longint det);
    longint q;
    q = (num * 256) / det;
    if (q > 8388607) q = 8388607;
    if (q < -8388608) q = -8388608;
    return q[23:0];
  endfunction

  function automatic crossing_t find_crossing(logic [127:0] d);
    longint c[8];
    int o1, o2, o3, o4;
    longint a1, b1, c1, a2, b2, c2, det;
    crossing_t r;
    for (int i = 0; i < 8; i++) c[i] = longint'($signed(d[16*i +: 16]));
    r = '0;
    o1 = side_of(c[0], c[1], c[2], c[3], c[4], c[5]);
    o2 = side_of(c[0], c[1], c[2], c[3], c[6], c[7]);
    o3 = side_of(c[4], c[5], c[6], c[7], c[0], c[1]);
    o4 = side_of(c[4], c[5], c[6], c[7], c[2], c[3]);
    if (o1 != o2 && o3 != o4) begin
      a1 = c[3] - c[1]; b1 = c[0] - c[2]; c1 = a1 * c[0] + b1 * c[1];
      a2 = c[7] - c[5]; b2 = c[4] - c[6]; c2 = a2 * c[4] + b2 * c[5];
      det = a1 * b2 - a2 * b1;
      if (det != 0) begin
        r.hit = 1'b1;
        r.has_point = 1'b1;
        r.x = fixed_quot(c1 * b2 - c2 * b1, det);
        r.y = fixed_quot(a1 * c2 - a2 * c1, det);
        return r;
      end
    end
    // collinear endpoint touching
    if (o1 == 0 && in_bounds(c[0], c[1], c[4], c[5], c[2], c[3])) r.hit = 1'b1;
    if (o2 == 0 && in_bounds(c[0], c[1], c[6], c[7], c[2], c[3])) r.hit = 1'b1;
    if (o3 == 0 && in_bounds(c[4], c[5], c[0], c[1], c[6], c[7])) r.hit = 1'b1;
    if (o4 == 0 && in_bounds(c[4], c[5], c[2], c[3], c[6], c[7])) r.hit = 1'b1;
    return r;
  endfunction

  // predict on input beats, compare on output beats
  always @(posedge clk) begin
    crossing_t want, got;
    if (rst) begin
      errors <= 0;
      crossings.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) crossings.push_back(find_crossing(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser[0], m_axis_tuser[1], m_axis_tdata[23:0], m_axis_tdata[47:24]};
        if (crossings.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result beat %h", got);
        end else begin
          want = crossings.pop_front();
          if (want !== got) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: hit %b/%b point %b/%b x %h/%h y %h/%h (exp/act)",
                       want.hit, got.hit, want.has_point, got.has_point,
                       want.x, got.x, want.y, got.y);
          end
        end
      end
    end
  end
endmodule

// ===== tb/segment_intersection_test_top_test.sv =====
// stimulus and verdict for the segment intersection block
// depends on segment_intersection_test_top and its checker
module segment_intersection_test_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  int           errors;
  int           pending;
  int           send_idle_pct = 21;
  int           recv_idle_pct = 57;
  int           hold_off = 0;
  bit           hold_req = 1'b0;
  bit           hold_used = 1'b0;
  bit           stim_done = 1'b0;

  always #5 clk = ~clk;

  segment_intersection_test_top uut (.*);

  segment_intersection_test_top_checker chk (.*);

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else if (hold_req && !hold_used) begin
      hold_used <= 1'b1;
      hold_off <= 300;
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(40)) - 20);
      default: return 16'($signed($urandom_range(2000)) - 1000);
    endcase
  endfunction

  // one pair per call; waits for the accepting edge
  task automatic send_pair(logic [127:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // random pair: general, small grid, shared endpoints, collinear or degenerate
  function automatic logic [127:0] rand_pair();
    logic [15:0] c[8];
    int mode, k;
    mode = $urandom_range(2);
    for (int i = 0; i < 8; i++) c[i] = rand_coord(mode);
    case ($urandom_range(5))
      0: begin c[4] = c[0]; c[5] = c[1]; end
      1: begin c[6] = c[2]; c[7] = c[3]; end
      2: begin
        // r and s on line pq through integer multiples
        k = $urandom_range(6);
        c[2] = c[0] + 16'($signed($urandom_range(8)) - 4);
        c[3] = c[1] + 16'($signed($urandom_range(8)) - 4);
        c[4] = c[0] + 16'(k - 3) * (c[2] - c[0]);
        c[5] = c[1] + 16'(k - 3) * (c[3] - c[1]);
        c[6] = c[0] + 16'($urandom_range(6) - 2) * (c[2] - c[0]);
        c[7] = c[1] + 16'($urandom_range(6) - 2) * (c[3] - c[1]);
      end
      3: begin c[2] = c[0]; c[3] = c[1]; end
      default: ;
    endcase
    return {c[7], c[6], c[5], c[4], c[3], c[2], c[1], c[0]};
  endfunction

  function automatic logic [127:0] pack(int px, int py, int qx, int qy,
                                        int rx, int ry, int sx, int sy);
    return {16'(sy), 16'(sx), 16'(ry), 16'(rx), 16'(qy), 16'(qx), 16'(py), 16'(px)};
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: crossing, touching, parallel, overlap, degenerate, extremes
    send_pair(pack(0, 0, 10, 10, 0, 10, 10, 0));
    send_pair(pack(0, 0, 10, 0, 5, 0, 5, 7));
    send_pair(pack(0, 0, 10, 0, 0, 1, 10, 1));
    send_pair(pack(0, 0, 10, 0, 5, 0, 20, 0));
    send_pair(pack(0, 0, 10, 0, 11, 0, 20, 0));
    send_pair(pack(3, 3, 3, 3, 0, 0, 6, 6));
    send_pair(pack(3, 4, 3, 4, 0, 0, 6, 6));
    send_pair(pack(2, 2, 2, 2, 2, 2, 2, 2));
    send_pair(pack(0, 0, 1, 3, 0, 1, 3, 0));
    send_pair(pack(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(pack(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    send_pair(pack(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
    send_pair(pack(-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767));
    send_pair(pack(0, 0, 1, 1, 5, 5, 9, 3));
    send_pair({128{1'b1}});
    send_pair('0);
    // random phases with differing idle rates
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle_pct = 57; recv_idle_pct = 21; end
      if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      if (ph == 0) hold_req <= 1'b1;
      for (int i = 0; i < 580; i++) send_pair(rand_pair());
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // verdict once all results are in
  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== segment_intersection_test_top.f =====
hdl/sit_pkg.sv
hdl/sit_div.sv
hdl/segment_intersection_test_top.sv
tb/segment_intersection_test_top_checker.sv
tb/segment_intersection_test_top_test.sv
